@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PDAF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pdaf check failed");

// next-cycle implication, checked out of reset
`define PDAF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pdaf check failed");

`endif

@@ hdl/pdaf_pkg.sv @@
// shared types and constants for the phase-detect autofocus update block
package pdaf_pkg;

    // default structural parameters
    localparam int MAX_REGIONS_DEF   = 256;
    localparam int HEADER_OFFSET_DEF = 4;
    localparam int MARKER_ID_DEF     = 0;
    localparam int ROW_STRIDE_DEF    = 80;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_GAIN       = 3'd1;
    localparam logic [2:0] REG_SLOPE      = 3'd2;
    localparam logic [2:0] REG_MOVE_LIMIT = 3'd3;
    localparam logic [2:0] REG_CONF_THR   = 3'd4;
    localparam logic [2:0] REG_AVG_FRAMES = 3'd5;
    localparam logic [2:0] REG_GRID_W     = 3'd6;
    localparam logic [2:0] REG_GRID_H     = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // divider widths
    localparam int DIVD_W = 37;
    localparam int DIVS_W = 11;

    // byte offset saturation point
    localparam logic [10:0] OFFSET_CAP = 11'h7FF;

    // reciprocal of five for an 11-bit value, shift of 14
    localparam logic [11:0] RECIP5 = 12'd3277;

    // one region's accumulators
    typedef struct packed {
        logic signed [19:0] phase_sum;
        logic [18:0]        conf_sum;
        logic [7:0]         hits;
    } entry_t;

    // region store control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_all;
    } mem_ctl_t;

endpackage

@@ hdl/phase_detect_autofocus_update.sv @@
// Phase-detect autofocus update: a byte is taken in the idle state; a byte that ends a
// region then probes the grid rows one at a time, reading and updating each region hit,
// and closes the probe; a last byte also passes through the end-of-frame step. A
// set-position request is taken in the idle state. An update pass reads every region and
// runs two divisions per region with hits on the one shared divider, then three more.
// Reset clears all region sums at once through valid bits; no clearing pass is needed.
// Position resets to 512 and all configuration registers to their documented defaults.
module phase_detect_autofocus_update #(
    parameter int MAX_REGIONS   = pdaf_pkg::MAX_REGIONS_DEF,
    parameter int HEADER_OFFSET = pdaf_pkg::HEADER_OFFSET_DEF,
    parameter int MARKER_ID     = pdaf_pkg::MARKER_ID_DEF,
    parameter int ROW_STRIDE    = pdaf_pkg::ROW_STRIDE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pdaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdaf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_last_byte,
    input  logic [9:0]                        s_position_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [9:0]                        m_lens_position,
    output logic signed [18:0]                m_phase_mean,
    output logic [18:0]                       m_confidence_mean
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int DW    = pdaf_pkg::DIVD_W;
    localparam int SW    = pdaf_pkg::DIVS_W;
    localparam logic [11:0] DEC_START  = 12'(HEADER_OFFSET + 2);
    localparam logic [12:0] STRIDE     = 13'(ROW_STRIDE);
    localparam logic [9:0]  MAX_IDX    = 10'(MAX_REGIONS);
    localparam logic [7:0]  MARKER     = 8'(MARKER_ID);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ROW    = 5'd1;
    localparam logic [4:0] S_RMW    = 5'd2;
    localparam logic [4:0] S_FEND   = 5'd3;
    localparam logic [4:0] S_SW_RD  = 5'd4;
    localparam logic [4:0] S_SW_CHK = 5'd5;
    localparam logic [4:0] S_SW_DP  = 5'd6;
    localparam logic [4:0] S_SW_DC  = 5'd7;
    localparam logic [4:0] S_MEAN_P = 5'd8;
    localparam logic [4:0] S_WAIT_P = 5'd9;
    localparam logic [4:0] S_WAIT_C = 5'd10;
    localparam logic [4:0] S_MUL1   = 5'd11;
    localparam logic [4:0] S_MUL2   = 5'd12;
    localparam logic [4:0] S_STEP   = 5'd13;
    localparam logic [4:0] S_WAIT_S = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    // configuration
    logic        enable_reg;
    logic [11:0] gain_reg;
    logic [10:0] slope_reg;
    logic [9:0]  move_limit_reg;
    logic [10:0] conf_thr_reg;
    logic [7:0]  avg_frames_reg;
    logic [4:0]  grid_w_reg;
    logic [4:0]  grid_h_reg;

    // control and frame state
    logic [4:0]  state_reg, state_next;
    logic [9:0]  position_reg, position_next;
    logic        marker_reg, marker_next;
    logic [10:0] offset_reg, offset_next;
    logic [15:0] pending_reg, pending_next;
    logic        frame_hit_reg, frame_hit_next;
    logic [7:0]  frames_done_reg, frames_done_next;
    logic        last_pend_reg, last_pend_next;
    logic        m_valid_reg, m_valid_next;

    // decode working registers
    logic signed [12:0] rem_reg, rem_next;
    logic [4:0]         h_reg, h_next;
    logic [8:0]         row_idx_reg, row_idx_next;
    logic [10:0]        conf_reg, conf_next;
    logic signed [10:0] ph_reg, ph_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    // update working registers
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [DW-1:0] sp_reg, sp_next;
    logic [18:0]        sc_reg, sc_next;
    logic [18:0]        cs_hold_reg, cs_hold_next;
    logic [7:0]         n_reg, n_next;
    logic signed [18:0] p_reg, p_next;
    logic [18:0]        c_reg, c_next;
    logic signed [38:0] prod_reg, prod_next;
    logic signed [51:0] num_reg, num_next;
    logic [9:0]         newpos_reg, newpos_next;

    // result registers
    logic [9:0]         m_pos_reg, m_pos_next;
    logic signed [18:0] m_phase_reg, m_phase_next;
    logic [18:0]        m_conf_reg, m_conf_next;

    // shared unit and store hookups
    logic                 div_start;
    logic signed [DW-1:0] div_dividend;
    logic [SW-1:0]        div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic signed [DW-1:0] div_q;
    pdaf_pkg::mem_ctl_t   mem_ctl;
    logic [IDX_W-1:0]     mem_rd_addr;
    pdaf_pkg::entry_t     mem_wr_data;
    pdaf_pkg::entry_t     mem_rd_data;

    // combinational helpers
    logic [4:0]         gw_eff, gh_eff;
    logic [7:0]         target;
    logic [10:0]        slope_eff;
    logic [10:0]        dec_conf;
    logic [22:0]        recip_prod;
    logic [8:0]         q5;
    logic [10:0]        m5;
    logic [9:0]         cand_idx;
    logic [7:0]         fd_inc, fd_new;
    logic               counted;
    logic [11:0]        k_rel;
    logic signed [52:0] t_sum;
    logic signed [DW-1:0] lim_s, step_c;
    logic signed [11:0] np;

    assign gw_eff    = (grid_w_reg > 5'd16) ? 5'd16 : grid_w_reg;
    assign gh_eff    = (grid_h_reg > 5'd16) ? 5'd16 : grid_h_reg;
    assign target    = (avg_frames_reg == 8'd0) ? 8'd1 : avg_frames_reg;
    assign slope_eff = (slope_reg == 11'd0) ? 11'd1 : slope_reg;
    assign dec_conf  = {pending_reg[15:8], pending_reg[7:5]};
    assign k_rel     = {1'b0, offset_reg} - DEC_START;

    // column of the current row by reciprocal multiply
    assign recip_prod = 23'(rem_reg[10:0]) * 23'(pdaf_pkg::RECIP5);
    assign q5         = recip_prod[22:14];
    assign m5         = rem_reg[10:0] - 11'(11'(q5) * 11'd5);
    assign cand_idx   = 10'(row_idx_reg) + 10'(q5);

    assign fd_inc  = (frames_done_reg == 8'd255) ? 8'd255 : frames_done_reg + 8'd1;
    assign counted = enable_reg && marker_reg && frame_hit_reg;
    assign fd_new  = counted ? fd_inc : frames_done_reg;

    assign t_sum  = 53'(num_reg) + $signed({15'd0, slope_eff, 27'd0});
    assign lim_s  = $signed(DW'(move_limit_reg));
    assign step_c = (div_q > lim_s) ? lim_s : ((div_q < -lim_s) ? -lim_s : div_q);
    assign np     = $signed({2'b00, position_reg}) - $signed(step_c[11:0]);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            gain_reg       <= 12'd256;
            slope_reg      <= 11'd20;
            move_limit_reg <= 10'd100;
            conf_thr_reg   <= 11'd10;
            avg_frames_reg <= 8'd4;
            grid_w_reg     <= 5'd8;
            grid_h_reg     <= 5'd8;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pdaf_pkg::REG_ENABLE:     enable_reg     <= cfg_data[0];
                pdaf_pkg::REG_GAIN:       gain_reg       <= cfg_data[11:0];
                pdaf_pkg::REG_SLOPE:      slope_reg      <= cfg_data[10:0];
                pdaf_pkg::REG_MOVE_LIMIT: move_limit_reg <= cfg_data[9:0];
                pdaf_pkg::REG_CONF_THR:   conf_thr_reg   <= cfg_data[10:0];
                pdaf_pkg::REG_AVG_FRAMES: avg_frames_reg <= cfg_data[7:0];
                pdaf_pkg::REG_GRID_W:     grid_w_reg     <= cfg_data[4:0];
                pdaf_pkg::REG_GRID_H:     grid_h_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        position_next    = position_reg;
        marker_next      = marker_reg;
        offset_next      = offset_reg;
        pending_next     = pending_reg;
        frame_hit_next   = frame_hit_reg;
        frames_done_next = frames_done_reg;
        last_pend_next   = last_pend_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        rem_next         = rem_reg;
        h_next           = h_reg;
        row_idx_next     = row_idx_reg;
        conf_next        = conf_reg;
        ph_next          = ph_reg;
        idx_next         = idx_reg;
        i_next           = i_reg;
        cnt_next         = cnt_reg;
        sp_next          = sp_reg;
        sc_next          = sc_reg;
        cs_hold_next     = cs_hold_reg;
        n_next           = n_reg;
        p_next           = p_reg;
        c_next           = c_reg;
        prod_next        = prod_reg;
        num_next         = num_reg;
        newpos_next      = newpos_reg;
        m_pos_next       = m_pos_reg;
        m_phase_next     = m_phase_reg;
        m_conf_next      = m_conf_reg;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;
        mem_ctl          = '0;
        mem_rd_addr      = idx_reg;
        mem_wr_data      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation) begin
                        position_next = s_position_value;
                    end else begin
                        if (enable_reg) begin
                            if (!marker_reg) begin
                                if (s_data_byte == MARKER) begin
                                    marker_next  = 1'b1;
                                    offset_next  = 11'd1;
                                    pending_next = {8'd0, s_data_byte};
                                end
                            end else if (offset_reg < pdaf_pkg::OFFSET_CAP) begin
                                pending_next = {pending_reg[7:0], s_data_byte};
                                offset_next  = offset_reg + 11'd1;
                                if ({1'b0, offset_reg} >= DEC_START
                                        && dec_conf >= conf_thr_reg) begin
                                    conf_next      = dec_conf;
                                    ph_next        = $signed({pending_reg[4:0],
                                                              s_data_byte[7:2]});
                                    rem_next       = $signed({1'b0, k_rel});
                                    h_next         = 5'd0;
                                    row_idx_next   = 9'd0;
                                    last_pend_next = s_last_byte;
                                    state_next     = S_ROW;
                                end
                            end
                        end
                        if (state_next == S_IDLE && s_last_byte) begin
                            state_next = S_FEND;
                        end
                    end
                end
            end

            // probe one grid row for a region ending here
            S_ROW: begin
                if (h_reg >= gh_eff || rem_reg < 0) begin
                    state_next = last_pend_reg ? S_FEND : S_IDLE;
                end else begin
                    rem_next     = rem_reg - $signed(STRIDE);
                    h_next       = h_reg + 5'd1;
                    row_idx_next = row_idx_reg + 9'(gw_eff);
                    if (m5 == 11'd0 && q5 < 9'(gw_eff) && cand_idx < MAX_IDX) begin
                        idx_next      = IDX_W'(cand_idx);
                        mem_rd_addr   = IDX_W'(cand_idx);
                        mem_ctl.rd_en = 1'b1;
                        state_next    = S_RMW;
                    end
                end
            end

            // accumulate into the region
            S_RMW: begin
                if (mem_rd_data.hits != 8'd255) begin
                    mem_ctl.wr_en         = 1'b1;
                    mem_wr_data.phase_sum = mem_rd_data.phase_sum + 20'(ph_reg);
                    mem_wr_data.conf_sum  = mem_rd_data.conf_sum + 19'(conf_reg);
                    mem_wr_data.hits      = mem_rd_data.hits + 8'd1;
                    frame_hit_next        = 1'b1;
                end
                state_next = S_ROW;
            end

            // end of frame
            S_FEND: begin
                marker_next    = 1'b0;
                offset_next    = '0;
                frame_hit_next = 1'b0;
                pending_next   = '0;
                if (counted && fd_inc >= target) begin
                    frames_done_next = '0;
                    i_next           = '0;
                    cnt_next         = '0;
                    sp_next          = '0;
                    sc_next          = '0;
                    state_next       = S_SW_RD;
                end else begin
                    frames_done_next  = fd_new;
                    mem_ctl.clear_all = (fd_new == 8'd0);
                    state_next        = S_IDLE;
                end
            end

            // sweep over the regions
            S_SW_RD: begin
                if (i_reg == CNT_W'(MAX_REGIONS)) begin
                    state_next = S_MEAN_P;
                end else begin
                    mem_rd_addr   = IDX_W'(i_reg);
                    mem_ctl.rd_en = 1'b1;
                    i_next        = i_reg + CNT_W'(1);
                    state_next    = S_SW_CHK;
                end
            end

            S_SW_CHK: begin
                if (mem_rd_data.hits == 8'd0) begin
                    state_next = S_SW_RD;
                end else begin
                    cs_hold_next = mem_rd_data.conf_sum;
                    n_next       = mem_rd_data.hits;
                    div_start    = 1'b1;
                    div_dividend = $signed({{(DW - 28){mem_rd_data.phase_sum[19]}},
                                            mem_rd_data.phase_sum, 8'd0});
                    div_divisor  = SW'(mem_rd_data.hits);
                    state_next   = S_SW_DP;
                end
            end

            S_SW_DP: begin
                if (div_done) begin
                    sp_next      = sp_reg + div_q;
                    div_start    = 1'b1;
                    div_dividend = $signed(DW'(cs_hold_reg));
                    div_divisor  = SW'(n_reg);
                    state_next   = S_SW_DC;
                end
            end

            S_SW_DC: begin
                if (div_done) begin
                    sc_next    = sc_reg + div_q[18:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_SW_RD;
                end
            end

            // grid means
            S_MEAN_P: begin
                if (cnt_reg == '0) begin
                    p_next     = '0;
                    c_next     = '0;
                    state_next = S_MUL1;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = sp_reg;
                    div_divisor  = SW'(cnt_reg);
                    state_next   = S_WAIT_P;
                end
            end

            S_WAIT_P: begin
                if (div_done) begin
                    p_next       = div_q[18:0];
                    div_start    = 1'b1;
                    div_dividend = $signed(DW'({sc_reg, 8'd0}));
                    div_divisor  = SW'(cnt_reg);
                    state_next   = S_WAIT_C;
                end
            end

            S_WAIT_C: begin
                if (div_done) begin
                    c_next     = div_q[18:0];
                    state_next = S_MUL1;
                end
            end

            // confidence times phase, then times gain
            S_MUL1: begin
                prod_next  = 39'($signed({1'b0, c_reg})) * 39'(p_reg);
                state_next = S_MUL2;
            end

            S_MUL2: begin
                num_next   = 52'(prod_reg) * $signed(52'({1'b0, gain_reg}));
                state_next = S_STEP;
            end

            // rounded move in lens steps
            S_STEP: begin
                div_start    = 1'b1;
                div_dividend = $signed({{(DW - 25){t_sum[52]}}, t_sum[52:28]});
                div_divisor  = slope_eff;
                state_next   = S_WAIT_S;
            end

            S_WAIT_S: begin
                if (div_done) begin
                    if (np < 0) begin
                        newpos_next = 10'd0;
                    end else if (np > 12'sd1023) begin
                        newpos_next = 10'd1023;
                    end else begin
                        newpos_next = np[9:0];
                    end
                    state_next = S_OUT;
                end
            end

            // hand the result over once the output register is free
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    position_next     = newpos_reg;
                    m_pos_next        = newpos_reg;
                    m_phase_next      = p_reg;
                    m_conf_next       = c_reg;
                    m_valid_next      = 1'b1;
                    mem_ctl.clear_all = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            position_reg    <= 10'd512;
            marker_reg      <= 1'b0;
            offset_reg      <= '0;
            pending_reg     <= '0;
            frame_hit_reg   <= 1'b0;
            frames_done_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            position_reg    <= position_next;
            marker_reg      <= marker_next;
            offset_reg      <= offset_next;
            pending_reg     <= pending_next;
            frame_hit_reg   <= frame_hit_next;
            frames_done_reg <= frames_done_next;
            m_valid_reg     <= m_valid_next;
        end
        last_pend_reg <= last_pend_next;
        rem_reg       <= rem_next;
        h_reg         <= h_next;
        row_idx_reg   <= row_idx_next;
        conf_reg      <= conf_next;
        ph_reg        <= ph_next;
        idx_reg       <= idx_next;
        i_reg         <= i_next;
        cnt_reg       <= cnt_next;
        sp_reg        <= sp_next;
        sc_reg        <= sc_next;
        cs_hold_reg   <= cs_hold_next;
        n_reg         <= n_next;
        p_reg         <= p_next;
        c_reg         <= c_next;
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        newpos_reg    <= newpos_next;
        m_pos_reg     <= m_pos_next;
        m_phase_reg   <= m_phase_next;
        m_conf_reg    <= m_conf_next;
    end

    // shared divider
    pdaf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // region accumulators
    pdaf_regions #(
        .MAX_REGIONS (MAX_REGIONS),
        .IDX_W       (IDX_W)
    ) u_regions (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (idx_reg),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_lens_position   = m_pos_reg;
    assign m_phase_mean      = m_phase_reg;
    assign m_confidence_mean = m_conf_reg;

    // checks
    `include "assert_macros.svh"

    `PDAF_ASSERT_IMP(a_div_idle_start, div_start, !div_busy)
    `PDAF_ASSERT_NXT(a_out_matches_pos, state_reg == S_OUT && (!m_valid_reg || m_ready),
        m_valid && m_lens_position == position_reg)
    `PDAF_ASSERT_NXT(a_frame_end_resets, state_reg == S_FEND,
        !marker_reg && offset_reg == '0 && !frame_hit_reg)

endmodule

@@ hdl/pdaf_div.sv @@
// shared iterative floor divider, one quotient bit per cycle
module pdaf_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [pdaf_pkg::DIVD_W-1:0] dividend,
    input  logic [pdaf_pkg::DIVS_W-1:0]       divisor,
    output logic                              busy,
    output logic                              done,
    output logic signed [pdaf_pkg::DIVD_W-1:0] quotient
);

    localparam int DW = pdaf_pkg::DIVD_W;
    localparam int SW = pdaf_pkg::DIVS_W;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] mag_reg, mag_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [SW:0]   trial;

    // restoring step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, mag_reg[DW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            mag_next  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[DW-1];
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = SW'(trial - {1'b0, dvs_reg});
                mag_next = {mag_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[SW-1:0];
                mag_next = {mag_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // floor correction for negative dividends
    always_comb begin
        if (!neg_reg) begin
            quotient = $signed(mag_reg);
        end else if (rem_reg != '0) begin
            quotient = $signed(~mag_reg);
        end else begin
            quotient = $signed(DW'(-mag_reg));
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

@@ hdl/pdaf_regions.sv @@
// per-region accumulator store with valid bits so that all regions clear at once
module pdaf_regions #(
    parameter int MAX_REGIONS = pdaf_pkg::MAX_REGIONS_DEF,
    parameter int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pdaf_pkg::mem_ctl_t  ctl,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  pdaf_pkg::entry_t    wr_data,
    output pdaf_pkg::entry_t    rd_data
);

    pdaf_pkg::entry_t         mem [MAX_REGIONS];
    logic [MAX_REGIONS-1:0]   valid_reg;
    pdaf_pkg::entry_t         rd_data_reg;
    logic                     rd_valid_reg;

    // valid bits, cleared together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.clear_all) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // storage array
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the phase-detect autofocus update block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR    = pdaf_pkg::HEADER_OFFSET_DEF;
    localparam int STRIDE = pdaf_pkg::ROW_STRIDE_DEF;
    localparam int NREG   = pdaf_pkg::MAX_REGIONS_DEF;
    localparam int LIMIT  = 4000000;

    typedef struct {
        bit       op;
        bit [7:0] data;
        bit       last;
        bit [9:0] pos;
    } af_req_t;

    typedef struct {
        bit [9:0]  lens;
        bit [18:0] phase;
        bit [18:0] conf;
    } af_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [pdaf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pdaf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic [9:0]  s_position_value = 10'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_lens_position;
    logic signed [18:0] m_phase_mean;
    logic [18:0] m_confidence_mean;

    phase_detect_autofocus_update dut (.*);

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    af_req_t pending_reqs[$];
    af_res_t lens_updates[$];
    int      errors = 0;
    int      items_sent = 0;
    int      updates_seen = 0;
    int      updates_due = 0;
    int      frames_built = 0;
    int      cycles = 0;
    bit      calm = 1'b0;
    bit      want_stall = 1'b0;
    bit      stall_armed = 1'b0;
    int      stall_left = 0;

    // register shadow
    int en_r = 0, gain_r = 256, slope_r = 20, lim_r = 100, thr_r = 10;
    int avg_r = 4, gw_r = 8, gh_r = 8;

    // focus state
    int       phase_acc[NREG];
    int       conf_acc[NREG];
    int       hits[NREG];
    int       frames_done = 0, lens_pos = 512, marker_seen = 0;
    int       offset = 0, frame_hits = 0, prev_bytes = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint floor_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    task automatic clear_regions();
        for (int i = 0; i < NREG; i++) begin
            phase_acc[i] = 0;
            conf_acc[i] = 0;
            hits[i] = 0;
        end
    endtask

    // decode any region whose third byte has just arrived
    task automatic decode_region(input int k, input int d2);
        int gw, gh, d0, d1, r, conf, raw, ph, base, rem, w, idx;
        gw = gw_r > 16 ? 16 : gw_r;
        gh = gh_r > 16 ? 16 : gh_r;
        d0 = (prev_bytes >> 8) & 255;
        d1 = prev_bytes & 255;
        if (k < HDR + 2) return;
        r = k - 2 - HDR;
        conf = (d0 << 3) + (d1 >> 5);
        raw = ((d1 & 31) << 6) + (d2 >> 2);
        ph = (raw & 1024) ? raw - 2048 : raw;
        if (conf < thr_r) return;
        for (int h = 0; h < gh; h++) begin
            base = h * STRIDE;
            if (r < base) break;
            rem = r - base;
            if (rem % 5 != 0) continue;
            w = rem / 5;
            if (w >= gw) continue;
            idx = h * gw + w;
            if (idx >= NREG || hits[idx] >= 255) continue;
            phase_acc[idx] += ph;
            conf_acc[idx] += conf;
            hits[idx]++;
            if (frame_hits < 256) frame_hits++;
        end
    endtask

    // grid means, lens move and new position
    task automatic compute_update();
        longint sp, sc, cnt, p, c, num, den, mv;
        af_res_t res;
        sp = 0; sc = 0; cnt = 0; p = 0; c = 0;
        for (int i = 0; i < NREG; i++) begin
            if (hits[i] != 0) begin
                sp += floor_div(longint'(phase_acc[i]) * 256, hits[i]);
                sc += conf_acc[i] / hits[i];
                cnt++;
            end
        end
        if (cnt != 0) begin
            p = floor_div(sp, cnt);
            c = (sc * 256) / cnt;
        end
        den = longint'(slope_r == 0 ? 1 : slope_r) * 268435456;
        num = c * p * gain_r;
        mv = floor_div(2 * num + den, 2 * den);
        if (mv > lim_r) mv = lim_r;
        if (mv < -lim_r) mv = -lim_r;
        mv = lens_pos - mv;
        if (mv < 0) mv = 0;
        if (mv > 1023) mv = 1023;
        lens_pos = int'(mv);
        res.lens = lens_pos[9:0];
        res.phase = p[18:0];
        res.conf = c[18:0];
        lens_updates.push_back(res);
        updates_due++;
    endtask

    task automatic predict(input af_req_t q);
        if (q.op) begin
            lens_pos = q.pos;
            return;
        end
        if (en_r != 0) begin
            if (marker_seen == 0) begin
                if (q.data == 8'(pdaf_pkg::MARKER_ID_DEF)) begin
                    marker_seen = 1;
                    offset = 1;
                    prev_bytes = q.data;
                end
            end else if (offset < 2047) begin
                decode_region(offset, q.data);
                prev_bytes = ((prev_bytes << 8) | q.data) & 16'hFFFF;
                offset++;
            end
        end
        if (q.last) begin
            if (en_r != 0 && marker_seen != 0 && frame_hits != 0) begin
                if (frames_done < 255) frames_done++;
                if (frames_done >= (avg_r == 0 ? 1 : avg_r)) begin
                    compute_update();
                    frames_done = 0;
                end
            end
            if (frames_done == 0) clear_regions();
            marker_seen = 0;
            offset = 0;
            frame_hits = 0;
            prev_bytes = 0;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        af_req_t q;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                q.op = s_operation;
                q.data = s_data_byte;
                q.last = s_last_byte;
                q.pos = s_position_value;
                predict(q);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
                    q = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= q.op;
                    s_data_byte <= q.data;
                    s_last_byte <= q.last;
                    s_position_value <= q.pos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (want_stall && !stall_armed) begin
            stall_armed <= 1'b1;
            stall_left <= 4000;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // result ready
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 22);
    end

    // result monitor
    always @(posedge aclk) begin
        af_res_t e;
        if (aresetn && m_valid && m_ready) begin
            updates_seen++;
            if (lens_updates.size() == 0) begin
                report("unexpected lens update", m_lens_position, -1);
            end else begin
                e = lens_updates.pop_front();
                if (m_lens_position !== e.lens)
                    report("lens_position", m_lens_position, e.lens);
                if (m_phase_mean !== e.phase)
                    report("phase_mean", m_phase_mean, $signed(e.phase));
                if (m_confidence_mean !== e.conf)
                    report("confidence_mean", m_confidence_mean, e.conf);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_req(input bit op, input int data, input bit last, input int pos);
        af_req_t q;
        q.op = op;
        q.data = data[7:0];
        q.last = last;
        q.pos = pos[9:0];
        pending_reqs.push_back(q);
    endtask

    task automatic write_reg(input logic [pdaf_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[pdaf_pkg::CFG_DATA_W-1:0];
        case (idx)
            pdaf_pkg::REG_ENABLE:     en_r = val & 1;
            pdaf_pkg::REG_GAIN:       gain_r = val & 12'hFFF;
            pdaf_pkg::REG_SLOPE:      slope_r = val & 11'h7FF;
            pdaf_pkg::REG_MOVE_LIMIT: lim_r = val & 10'h3FF;
            pdaf_pkg::REG_CONF_THR:   thr_r = val & 11'h7FF;
            pdaf_pkg::REG_AVG_FRAMES: avg_r = val & 8'hFF;
            pdaf_pkg::REG_GRID_W:     gw_r = val & 5'h1F;
            pdaf_pkg::REG_GRID_H:     gh_r = val & 5'h1F;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic setup(input int g, input int sl, input int lim, input int thr,
                         input int avg, input int gw, input int gh);
        write_reg(pdaf_pkg::REG_GAIN, g);
        write_reg(pdaf_pkg::REG_SLOPE, sl);
        write_reg(pdaf_pkg::REG_MOVE_LIMIT, lim);
        write_reg(pdaf_pkg::REG_CONF_THR, thr);
        write_reg(pdaf_pkg::REG_AVG_FRAMES, avg);
        write_reg(pdaf_pkg::REG_GRID_W, gw);
        write_reg(pdaf_pkg::REG_GRID_H, gh);
    endtask

    // wait until the block has drained
    task automatic settle();
        while (pending_reqs.size() != 0 || s_valid || lens_updates.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // one embedded frame sized for the grid, sometimes cut short or noisy
    task automatic add_frame(input int cols, input int rows, input int force_len);
        int need, len, sel;
        sel = $urandom_range(19);
        frames_built++;
        repeat ($urandom_range(2)) push_req(0, $urandom_range(1, 255), 0, $urandom_range(1023));
        if (sel == 0) begin
            // no marker at all
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
                push_req(0, $urandom_range(1, 255), i == len - 1, $urandom_range(1023));
            return;
        end
        need = HDR + STRIDE * (rows - 1) + 5 * (cols - 1) + 2;
        if (force_len > 0) len = force_len;
        else if (sel == 1) len = $urandom_range(need);
        else len = need + $urandom_range(4);
        push_req(0, pdaf_pkg::MARKER_ID_DEF, len == 0, $urandom_range(1023));
        for (int i = 1; i <= len; i++) begin
            if ($urandom_range(39) == 0)
                push_req(1, $urandom_range(255), $urandom_range(1), $urandom_range(1023));
            push_req(0, $urandom_range(255), i == len, $urandom_range(1023));
        end
    endtask

    task automatic run_frames(input int n_items, input int cols, input int rows);
        int start;
        start = pending_reqs.size();
        while (pending_reqs.size() - start < n_items) add_frame(cols, rows, 0);
        settle();
    endtask

    initial begin
        clear_regions();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes on a single region
        write_reg(pdaf_pkg::REG_ENABLE, 1);
        setup(4095, 1, 1023, 0, 1, 1, 1);
        push_req(1, 255, 1, 0);
        push_req(0, 0, 0, 1023);
        push_req(0, 255, 0, 0);
        push_req(0, 255, 0, 0);
        push_req(0, 255, 0, 0);
        push_req(0, 255, 0, 0);
        push_req(0, 8'hEF, 0, 0);
        push_req(0, 8'hFC, 1, 0);
        push_req(1, 0, 0, 1023);
        push_req(0, 0, 0, 0);
        push_req(0, 0, 0, 0);
        push_req(0, 0, 0, 0);
        push_req(0, 0, 0, 0);
        push_req(0, 255, 0, 0);
        push_req(0, 8'hF0, 0, 0);
        push_req(0, 8'h00, 1, 0);
        push_req(0, 0, 1, 0);
        push_req(0, 7, 0, 0);
        push_req(0, 0, 0, 0);
        push_req(0, 1, 1, 0);
        settle();

        // reset-like settings, mid-size grid
        setup(256, 20, 100, 10, 2, 4, 3);
        run_frames(300, 4, 3);

        // sender keeps offering while the receiver holds off
        setup(300, 3, 50, 5, 1, 1, 1);
        calm = 1'b1;
        want_stall = 1'b1;
        run_frames(250, 1, 1);
        calm = 1'b0;

        // full-width grid over its first rows
        setup(4095, 1, 1023, 0, 1, 16, 16);
        add_frame(16, 16, 600);
        settle();

        // opposite extremes and odd grid sizes
        setup(0, 2047, 0, 2047, 3, 0, 31);
        run_frames(150, 1, 1);
        setup(2000, 0, 1023, 1000, 0, 31, 2);
        run_frames(250, 16, 2);

        // autofocus off
        write_reg(pdaf_pkg::REG_ENABLE, 0);
        run_frames(100, 2, 1);
        write_reg(pdaf_pkg::REG_ENABLE, 1);

        // random settings until the request budget is spent
        while (items_sent < 1900) begin
            setup($urandom_range(4095), $urandom_range(64), $urandom_range(1023),
                  $urandom_range(300), $urandom_range(3), $urandom_range(1, 5),
                  $urandom_range(1, 3));
            run_frames(150, gw_r, gh_r);
        end

        repeat (300) @(posedge aclk);
        $display("%0d requests over %0d frames, %0d lens updates checked", items_sent,
                 frames_built, updates_seen);
        $display("covered extreme settings, wide grid, long hold-off and disabled frames");
        if (errors == 0 && lens_updates.size() == 0 && updates_seen == updates_due) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/pdaf_pkg.sv
hdl/pdaf_div.sv
hdl/pdaf_regions.sv
hdl/phase_detect_autofocus_update.sv
sim/testbench.sv
